/* sv/coupled_pwlcm_generator_macros.svh */
// Assertion macros for the coupled PWLCM generator.
// Used by coupled_pwlcm_generator.sv; expects clk and rst_n in scope.
`ifndef COUPLED_PWLCM_GENERATOR_MACROS_SVH
`define COUPLED_PWLCM_GENERATOR_MACROS_SVH

// Same-cycle implication, checked out of reset
`define CPW_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset
`define CPW_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/cpwlcm_pkg.sv */
// Shared constants and codes for the coupled PWLCM generator.
// No dependencies; imported by coupled_pwlcm_generator.
package cpwlcm_pkg;

  // Default map word width
  localparam int WORD_BITS_DEF = 32;

  // Fixed port widths
  localparam int PARAM_W    = 31;
  localparam int SEED_W     = 32;
  localparam int KS_W       = 32;
  localparam int CFG_ADDR_W = 1;

  // Control parameter value after reset
  localparam logic [PARAM_W-1:0] PARAM_RESET = PARAM_W'(1073741823);

  // Opcodes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // Register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_PARAM_A = CFG_ADDR_W'(0);
  localparam logic [CFG_ADDR_W-1:0] REG_PARAM_B = CFG_ADDR_W'(1);

endpackage

/* sv/coupled_pwlcm_generator.sv */
// Coupled PWLCM generator: two cross-coupled piecewise linear chaotic maps.
// Depends on cpwlcm_pkg and coupled_pwlcm_generator_macros.svh.
//
// One transaction at a time. A step transaction runs each map through a
// region-select state and three passes through the single WORD_BITS x WORD_BITS
// multiplier (a map at zero skips the multiplier), then the finish state forms
// the keystream word and shifts the maps once the output register is free. A
// load transaction is paced by the radix-2 restoring divider that computes the
// four reciprocals one quotient bit per cycle, and then emits a zero result.
// in_ready is high only between transactions; a finished result sits in the
// output register while the next transaction is accepted.
`include "coupled_pwlcm_generator_macros.svh"

module coupled_pwlcm_generator
  import cpwlcm_pkg::*;
#(
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  // configuration
  input  logic                  cfg_we,
  input  logic [CFG_ADDR_W-1:0] cfg_addr,
  input  logic [PARAM_W-1:0]    cfg_wdata,
  // input transaction
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_opcode,
  input  logic [SEED_W-1:0]     in_seed_a,
  input  logic [SEED_W-1:0]     in_seed_b,
  input  logic                  in_bit,
  // result transaction
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KS_W-1:0]       out_keystream,
  output logic                  out_feedback_bit
);

  localparam int W      = WORD_BITS;
  localparam int W2     = 2 * WORD_BITS;
  localparam int DCNT_W = $clog2(W2);

  localparam logic [DCNT_W-1:0] DCNT_LAST = DCNT_W'(W2 - 1);
  localparam logic [63:0] M1_64   = (64'd1 << W) - 64'd1;
  localparam logic [63:0] HALF_64 = 64'd1 << (W - 1);
  localparam logic [W2-1:0] NUMER = {{W{1'b1}}, {W{1'b0}}};
  localparam logic [W-1:0]  ZERO_MAP_NEXT = {{(W-1){1'b1}}, 1'b0};

  // multiplier pass codes
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SEL,
    ST_MUL,
    ST_FIN
  } state_t;

  state_t             state_r;
  logic [PARAM_W-1:0] param_a_r, param_b_r;
  logic [W-1:0]       map_a_r, map_b_r;
  logic [W2-1:0]      recip_r [4];
  logic               s_r, load_r, sel_r, rhi_r;
  logic [W2-1:0]      op_r;
  logic [W-1:0]       acc_r;
  logic [1:0]         mcnt_r, div_idx_r;
  logic [DCNT_W-1:0]  div_cnt_r;
  logic [63:0]        rem_r;
  logic [W2-1:0]      quo_r;
  logic               out_valid_r, out_fb_r;
  logic [KS_W-1:0]    out_ks_r;

  assign in_ready         = (state_r == ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_keystream    = out_ks_r;
  assign out_feedback_bit = out_fb_r;

  // Divisor for the reciprocal being computed
  logic [63:0] divisor;
  always_comb begin
    case (div_idx_r)
      2'd0:    divisor = 64'(param_a_r);
      2'd1:    divisor = HALF_64 - 64'(param_a_r);
      2'd2:    divisor = 64'(param_b_r);
      default: divisor = HALF_64 - 64'(param_b_r);
    endcase
  end

  // One restoring division step
  logic [64:0]   rem_sh, rem_sub;
  logic          div_ge;
  logic [63:0]   rem_nxt;
  logic [W2-1:0] quo_nxt, recip_nxt;
  assign rem_sh    = {rem_r, quo_r[W2-1]};
  assign div_ge    = (rem_sh >= {1'b0, divisor});
  assign rem_sub   = rem_sh - {1'b0, divisor};
  assign rem_nxt   = div_ge ? rem_sub[63:0] : rem_sh[63:0];
  assign quo_nxt   = {quo_r[W2-2:0], div_ge};
  assign recip_nxt = (divisor == 64'd0) ? {W2{1'b1}} : quo_nxt;

  // Region select for the current map
  logic [63:0]   x64, p64, m1p, op64;
  logic          in_r1, in_r2, in_r3, in_r4, is_zero_case;
  assign x64   = 64'(sel_r ? map_b_r : map_a_r);
  assign p64   = 64'(sel_r ? param_b_r : param_a_r);
  assign m1p   = M1_64 - p64;
  assign in_r1 = (x64 != 64'd0) && (x64 <= p64);
  assign in_r2 = (x64 > p64) && (x64 <= HALF_64);
  assign in_r3 = (x64 > HALF_64) && (x64 <= m1p);
  assign in_r4 = (x64 > m1p) && (x64 <= M1_64);
  assign is_zero_case = !(in_r1 || in_r2 || in_r3 || in_r4);

  always_comb begin
    if (in_r1)      op64 = x64;
    else if (in_r2) op64 = x64 - p64;
    else if (in_r3) op64 = m1p - x64;
    else            op64 = M1_64 - x64;
  end

  // Shared multiplier: bits [2W-1:W] of op * recip, taken as three partial products
  logic [W2-1:0] recip_sel, prod;
  logic [W-1:0]  mul_a, mul_b, acc_sum;
  assign recip_sel = recip_r[{sel_r, rhi_r}];
  always_comb begin
    case (mcnt_r)
      MUL_LL: begin
        mul_a = op_r[W-1:0];
        mul_b = recip_sel[W-1:0];
      end
      MUL_LH: begin
        mul_a = op_r[W-1:0];
        mul_b = recip_sel[W2-1:W];
      end
      default: begin
        mul_a = op_r[W2-1:W];
        mul_b = recip_sel[W-1:0];
      end
    endcase
  end
  assign prod    = W2'(mul_a) * W2'(mul_b);
  assign acc_sum = acc_r + prod[W-1:0];

  // Sequencer, state and registered outputs
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      param_a_r   <= PARAM_RESET;
      param_b_r   <= PARAM_RESET;
      map_a_r     <= '0;
      map_b_r     <= '0;
      for (int i = 0; i < 4; i++) recip_r[i] <= '0;
      out_valid_r <= 1'b0;
      mcnt_r      <= MUL_LL;
      div_idx_r   <= 2'd0;
      div_cnt_r   <= '0;
      sel_r       <= 1'b0;
      rhi_r       <= 1'b0;
      load_r      <= 1'b0;
    end else begin
      // register writes
      if (cfg_we) begin
        case (cfg_addr)
          REG_PARAM_A: param_a_r <= cfg_wdata;
          REG_PARAM_B: param_b_r <= cfg_wdata;
          default: ;
        endcase
      end

      // result taken; ST_FIN refills the register itself
      if (out_valid_r && out_ready && (state_r != ST_FIN)) out_valid_r <= 1'b0;

      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            s_r   <= in_bit;
            sel_r <= 1'b0;
            if (in_opcode == OP_LOAD) begin
              load_r    <= 1'b1;
              map_a_r   <= in_seed_a[W-1:0];
              map_b_r   <= in_seed_b[W-1:0];
              div_idx_r <= 2'd0;
              div_cnt_r <= '0;
              rem_r     <= '0;
              quo_r     <= NUMER;
              state_r   <= ST_DIV;
            end else begin
              load_r  <= 1'b0;
              state_r <= ST_SEL;
            end
          end
        end

        // one quotient bit per cycle, four reciprocals in turn
        ST_DIV: begin
          if (div_cnt_r == DCNT_LAST) begin
            recip_r[div_idx_r] <= recip_nxt;
            rem_r     <= '0;
            quo_r     <= NUMER;
            div_cnt_r <= '0;
            if (div_idx_r == 2'd3) state_r <= ST_FIN;
            else div_idx_r <= div_idx_r + 2'd1;
          end else begin
            rem_r     <= rem_nxt;
            quo_r     <= quo_nxt;
            div_cnt_r <= div_cnt_r + DCNT_W'(1);
          end
        end

        // pick region; a map at zero goes straight to M1 - 1
        ST_SEL: begin
          if (is_zero_case) begin
            if (sel_r) begin
              map_b_r <= ZERO_MAP_NEXT;
              state_r <= ST_FIN;
            end else begin
              map_a_r <= ZERO_MAP_NEXT;
              sel_r   <= 1'b1;
            end
          end else begin
            op_r    <= op64[W2-1:0];
            rhi_r   <= in_r2 || in_r3;
            mcnt_r  <= MUL_LL;
            state_r <= ST_MUL;
          end
        end

        // accumulate bits [2W-1:W] of the product
        ST_MUL: begin
          case (mcnt_r)
            MUL_LL: begin
              acc_r  <= prod[W2-1:W];
              mcnt_r <= MUL_LH;
            end
            MUL_LH: begin
              acc_r  <= acc_sum;
              mcnt_r <= MUL_HL;
            end
            default: begin
              mcnt_r <= MUL_LL;
              if (sel_r) begin
                map_b_r <= acc_sum;
                state_r <= ST_FIN;
              end else begin
                map_a_r <= acc_sum;
                sel_r   <= 1'b1;
                state_r <= ST_SEL;
              end
            end
          endcase
        end

        // emit result once the output register is free; a step also shifts in s
        ST_FIN: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            if (load_r) begin
              out_ks_r <= '0;
              out_fb_r <= 1'b0;
            end else begin
              out_ks_r <= KS_W'(map_a_r ^ map_b_r);
              out_fb_r <= (s_r & map_a_r[W-1]) ^ map_b_r[0];
              map_a_r  <= {map_a_r[W-2:0], s_r};
              map_b_r  <= {s_r, map_b_r[W-1:1]};
            end
            state_r <= ST_IDLE;
          end
        end

        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // Checks
  logic fin_emit;
  assign fin_emit = (state_r == ST_FIN) && (!out_valid_r || out_ready);

  `CPW_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "accepted while busy")
  `CPW_ASSERT_NEXT(a_fin_emits, fin_emit, out_valid_r && in_ready, "result not emitted")
  `CPW_ASSERT_NOW(a_mul_pass, state_r == ST_MUL, mcnt_r <= MUL_HL, "bad multiplier pass")

endmodule
